// ===== rtl/ptamr_pkg.sv =====
package ptamr_pkg;

  localparam int RANGE_W      = 17;
  localparam int CORDIC_STEPS = 28;
  localparam int PRE_SHIFT    = 12;
  localparam int ITER_W       = 5;

  localparam logic [RANGE_W-1:0] RANGE_MASK = {RANGE_W{1'b1}};

  // arctangent of 2^-i in binary angle units (2^32 per turn)
  function automatic logic [31:0] atan_at(input logic [ITER_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/point_to_angular_min_range_bins_unit.sv =====
// planar scan builder: keeps the minimum range of lidar points per angle bin
//
// s_* channel: one word per item. s_tuser is the kind (0 point, 1 read bin).
//   points go through a 28-step cordic for the angle bin and an 18-step
//   square root for the range, then a read-modify-write of the bin memory;
//   no new item is taken until the point is done.
//   a read item does a memory read, then the word is loaded into the output
//   register and the bin is cleared to the no-return marker.
//   a read of a bin at or beyond NUM_BINS gives no word and changes nothing.
// m_* channel: one word per valid read. a stalled receiver holds the output
//   register; a further read then waits inside the block with s_tready low
//   until that word is taken, so no item moves meanwhile.
// cfg_we/cfg_data write the range limit register; empty bins read as that
//   value plus 1000 (saturated) with the no_return flag in m_tuser.
// reset: a clearing pass sets all NUM_BINS entries to the marker, one per
//   cycle, and s_tready stays low until the pass is done.
module point_to_angular_min_range_bins_unit #(
  parameter int NUM_BINS = 360
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // x_mm[17:0], y_mm[35:18], read_bin[44:36], zero pad
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // bin_index[8:0], range_mm[25:9], zero pad
  output logic        m_tuser,   // no_return
  input  logic        cfg_we,
  input  logic [16:0] cfg_data
);

  localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int RW    = ptamr_pkg::RANGE_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_GEO  = 3'd2;
  localparam logic [2:0] S_PUPD = 3'd3;
  localparam logic [2:0] S_RRD  = 3'd4;
  localparam logic [2:0] S_ROUT = 3'd5;

  logic [2:0] state;
  logic [RW-1:0] range_ceil;
  logic [BIN_W-1:0] addr;
  logic [8:0] rd_bin;
  logic [RW-1:0] pt_range;

  // bin memory
  logic [RW-1:0] mem [NUM_BINS];
  logic [RW-1:0] rdata;
  logic mem_we, mem_re;
  logic [RW-1:0] mem_wdata;

  logic geo_start, geo_done;
  logic [BIN_W-1:0] geo_bin;
  logic [RW-1:0] geo_range;

  logic [RW:0] lim_sum;
  logic [RW-1:0] lim;
  logic accept, rd_ok;

  ptamr_geom #(.NUM_BINS(NUM_BINS), .BIN_W(BIN_W)) u_geom (
    .clk      (clk),
    .rst      (rst),
    .start    (geo_start),
    .x_mm     ($signed(s_tdata[17:0])),
    .y_mm     ($signed(s_tdata[35:18])),
    .done     (geo_done),
    .bin      (geo_bin),
    .range_mm (geo_range)
  );

  always_comb begin
    lim_sum   = {1'b0, range_ceil} + (RW+1)'(1000);
    lim       = lim_sum[RW] ? ptamr_pkg::RANGE_MASK : lim_sum[RW-1:0];
    s_tready  = (state == S_IDLE);
    accept    = s_tvalid && s_tready;
    rd_ok     = (11'(s_tdata[44:36]) < 11'(NUM_BINS));
    geo_start = accept && !s_tuser;
    mem_re    = (state == S_GEO && geo_done) || (state == S_RRD);
    mem_we    = 1'b0;
    mem_wdata = ptamr_pkg::RANGE_MASK;
    unique case (state)
      S_CLR:  mem_we = 1'b1;
      S_PUPD: begin
        // keep the smaller in-range value
        mem_we    = (pt_range < lim) && (pt_range < rdata);
        mem_wdata = pt_range;
      end
      S_ROUT: mem_we = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= mem_wdata;
    if (mem_re) rdata <= mem[(state == S_GEO) ? geo_bin : addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      addr       <= '0;
      range_ceil <= 17'd100000;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) range_ceil <= cfg_data;
      if (m_tvalid && m_tready && state != S_ROUT) m_tvalid <= 1'b0;
      unique case (state)
        S_CLR: begin
          addr <= addr + 1'b1;
          if (addr == BIN_W'(NUM_BINS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            if (!s_tuser) begin
              state <= S_GEO;
            end else if (rd_ok) begin
              addr  <= BIN_W'(s_tdata[44:36]);
              state <= S_RRD;
            end
          end
        end
        S_GEO: begin
          if (geo_done) begin
            addr  <= geo_bin;
            state <= S_PUPD;
          end
        end
        S_PUPD: state <= S_IDLE;
        S_RRD:  state <= S_ROUT;
        S_ROUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) rd_bin <= s_tdata[44:36];
    if (state == S_GEO && geo_done) pt_range <= geo_range;
    if (state == S_ROUT && (!m_tvalid || m_tready)) begin
      m_tdata[8:0]   <= rd_bin;
      m_tdata[25:9]  <= (rdata >= lim) ? lim : rdata;
      m_tdata[31:26] <= '0;
      m_tuser        <= (rdata >= lim);
    end
  end

endmodule

// ===== rtl/ptamr_geom.sv =====
module ptamr_geom #(
  parameter int NUM_BINS = 360,
  parameter int BIN_W    = 9
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [17:0]                 x_mm,
  input  logic signed [17:0]                 y_mm,
  output logic                               done,
  output logic [BIN_W-1:0]                   bin,
  output logic [ptamr_pkg::RANGE_W-1:0]      range_mm
);

  localparam logic [2:0] G_IDLE = 3'd0;
  localparam logic [2:0] G_MUL  = 3'd1;
  localparam logic [2:0] G_SUM  = 3'd2;
  localparam logic [2:0] G_RUN  = 3'd3;
  localparam logic [2:0] G_ANG  = 3'd4;
  localparam logic [2:0] G_BIN  = 3'd5;

  localparam int PW = 32 + BIN_W + 1;

  logic [2:0] state;
  logic [ptamr_pkg::ITER_W-1:0] it;
  logic [17:0] ax, ay;
  logic xneg, yneg, swap, on_xaxis, on_yaxis, on_diag, neg_xaxis;
  logic [35:0] sqx, sqy, sq;
  logic [20:0] rem;
  logic [17:0] root;
  logic signed [33:0] cx, cy;
  logic signed [31:0] z;
  logic [31:0] ang;

  logic [17:0] ax_c, ay_c, ca, cb;
  logic signed [33:0] dx, dy;
  logic [20:0] rem_sh;
  logic [19:0] trial;
  logic [31:0] zc, phi, quad, ang_c;
  logic [PW-1:0] prod;

  always_comb begin
    ax_c = x_mm[17] ? 18'(-x_mm) : 18'(x_mm);
    ay_c = y_mm[17] ? 18'(-y_mm) : 18'(y_mm);
    ca = (ay_c >= ax_c) ? ay_c : ax_c;
    cb = (ay_c >= ax_c) ? ax_c : ay_c;
    dx = cy >>> it;
    dy = cx >>> it;
    rem_sh = {rem[18:0], sq[35:34]};
    trial = {root, 2'b01};
    // clamp to the first octant
    if (z < 0) zc = 32'd0;
    else if (z > 32'sd536870912) zc = 32'd536870912;
    else zc = 32'(z);
    priority if (on_xaxis) phi = 32'd0;
    else if (on_yaxis) phi = 32'd1073741824;
    else if (on_diag) phi = 32'd536870912;
    else if (swap) phi = 32'd1073741824 - zc;
    else phi = zc;
    unique case ({xneg, yneg})
      2'b00:   quad = phi;
      2'b10:   quad = 32'h8000_0000 - phi;
      2'b11:   quad = 32'h8000_0000 + phi;
      default: quad = 32'd0 - phi;
    endcase
    ang_c = quad + 32'h8000_0000;
    prod = PW'(ang) * PW'(NUM_BINS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        G_IDLE: begin
          if (start) state <= G_MUL;
        end
        G_MUL: state <= G_SUM;
        G_SUM: state <= G_RUN;
        G_RUN: begin
          if (it == 5'(ptamr_pkg::CORDIC_STEPS - 1)) state <= G_ANG;
        end
        G_ANG: state <= G_BIN;
        G_BIN: begin
          state <= G_IDLE;
          done  <= 1'b1;
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      G_IDLE: begin
        ax        <= ax_c;
        ay        <= ay_c;
        xneg      <= x_mm[17];
        yneg      <= y_mm[17];
        swap      <= (ay_c >= ax_c);
        on_xaxis  <= (ay_c == 18'd0);
        on_yaxis  <= (ax_c == 18'd0);
        on_diag   <= (ax_c == ay_c);
        neg_xaxis <= (y_mm == 18'sd0) && x_mm[17];
        cx        <= $signed({4'b0, ca, 12'b0});
        cy        <= $signed({4'b0, cb, 12'b0});
        z         <= 32'sd0;
        it        <= '0;
      end
      G_MUL: begin
        sqx <= ax * ax;
        sqy <= ay * ay;
      end
      G_SUM: begin
        sq   <= sqx + sqy;
        rem  <= '0;
        root <= '0;
      end
      G_RUN: begin
        it <= it + 5'd1;
        if (!cy[33]) begin
          cx <= cx + dx;
          cy <= cy - dy;
          z  <= z + $signed(ptamr_pkg::atan_at(it));
        end else begin
          cx <= cx - dx;
          cy <= cy + dy;
          z  <= z - $signed(ptamr_pkg::atan_at(it));
        end
        // one root bit per step for the first 18 steps
        if (it < 5'd18) begin
          sq <= {sq[33:0], 2'b00};
          if (rem_sh >= {1'b0, trial}) begin
            rem  <= rem_sh - {1'b0, trial};
            root <= {root[16:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[16:0], 1'b0};
          end
        end
      end
      G_ANG: ang <= ang_c;
      G_BIN: begin
        bin      <= neg_xaxis ? BIN_W'(NUM_BINS - 1) : prod[32 +: BIN_W];
        range_mm <= root[17] ? ptamr_pkg::RANGE_MASK : root[16:0];
      end
      default: ;
    endcase
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;

  localparam int NBINS      = 360;
  localparam int SETTLE     = 60;    // point pipeline depth plus margin
  localparam int STUCK_MAX  = 4000;  // idle cycles before the watchdog fires
  localparam int HOLD_LEN   = 400;   // long receiver hold-off
  localparam bit KIND_POINT = 1'b0;
  localparam bit KIND_READ  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic [8:0]         rbin;
  } scan_item_t;

  typedef struct packed {
    logic [8:0]                    bin;
    logic [ptamr_pkg::RANGE_W-1:0] range;
    logic                          empty;
  } bin_word_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // x_mm[17:0], y_mm[35:18], read_bin[44:36], zero pad
  logic        s_tuser;   // kind
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // bin_index[8:0], range_mm[25:9], zero pad
  logic        m_tuser;   // no_return
  logic        cfg_we;
  logic [16:0] cfg_data;

  point_to_angular_min_range_bins_unit #(.NUM_BINS(NBINS)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // shadow of the block: per-bin minimum range and the range limit register
  logic [ptamr_pkg::RANGE_W-1:0] shadow_min [NBINS];
  logic [16:0]                   ceil_shadow;

  scan_item_t pending_items [$];
  bin_word_t  expected_words [$];

  int errors     = 0;
  int words_in   = 0;
  int words_out  = 0;
  int empty_seen = 0;
  int stuck      = 0;
  bit long_hold  = 0;

  // ---------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------

  // first-octant angle (b < a) by 28-step vectoring cordic, binary angle units
  function automatic longint octant_cordic(longint a, longint b);
    longint cx, cy, z, dx, dy;
    cx = a <<< ptamr_pkg::PRE_SHIFT;
    cy = b <<< ptamr_pkg::PRE_SHIFT;
    z  = 0;
    for (int i = 0; i < ptamr_pkg::CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy;
        z += longint'(ptamr_pkg::atan_at(i[ptamr_pkg::ITER_W-1:0]));
      end else begin
        cx -= dx; cy += dy;
        z -= longint'(ptamr_pkg::atan_at(i[ptamr_pkg::ITER_W-1:0]));
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd1 <<< 29)) z = 64'sd1 <<< 29;
    return z;
  endfunction

  function automatic int angle_bin(longint x, longint y);
    longint ax, ay;
    logic [31:0] phi, ang;
    longint unsigned prod;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    if (x == 0 && y == 0) return NBINS / 2;
    // negative x axis sits at +pi, clamped into the last bin
    if (y == 0 && x < 0) return NBINS - 1;
    if (ay == 0)       phi = 32'd0;
    else if (ax == 0)  phi = 32'h4000_0000;
    else if (ax == ay) phi = 32'h2000_0000;
    else if (ay < ax)  phi = 32'(octant_cordic(ax, ay));
    else               phi = 32'h4000_0000 - 32'(octant_cordic(ay, ax));
    if (x >= 0 && y >= 0) ang = phi;
    else if (x < 0 && y >= 0) ang = 32'h8000_0000 - phi;
    else if (x < 0) ang = 32'h8000_0000 + phi;
    else ang = 32'd0 - phi;
    ang += 32'h8000_0000;
    prod = (64'(ang) * 64'(NBINS)) >> 32;
    return (prod >= NBINS) ? NBINS - 1 : int'(prod);
  endfunction

  function automatic logic [ptamr_pkg::RANGE_W-1:0] planar_range(longint x, longint y);
    longint unsigned n, root, bitv;
    n = longint'(x * x + y * y);
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return (root > ptamr_pkg::RANGE_MASK) ? ptamr_pkg::RANGE_MASK
                                          : root[ptamr_pkg::RANGE_W-1:0];
  endfunction

  function automatic logic [ptamr_pkg::RANGE_W-1:0] empty_limit();
    int unsigned l;
    l = ceil_shadow + 1000;
    return (l > ptamr_pkg::RANGE_MASK) ? ptamr_pkg::RANGE_MASK
                                       : l[ptamr_pkg::RANGE_W-1:0];
  endfunction

  // apply one accepted item to the shadow, queue the word it should give
  task automatic track_item(scan_item_t it);
    logic [ptamr_pkg::RANGE_W-1:0] lim, r, v;
    bin_word_t w;
    int b;
    lim = empty_limit();
    if (it.kind == KIND_POINT) begin
      r = planar_range(it.x, it.y);
      b = angle_bin(it.x, it.y);
      // far points leave the bin alone
      if (r < lim && r < shadow_min[b]) shadow_min[b] = r;
    end else if (it.rbin < NBINS) begin
      v = shadow_min[it.rbin];
      shadow_min[it.rbin] = ptamr_pkg::RANGE_MASK;
      w.bin   = it.rbin;
      w.empty = (v >= lim);
      w.range = w.empty ? lim : v;
      expected_words.push_back(w);
    end
  endtask

  // ---------------------------------------------------------------
  // clock, driver, receiver, watchdog
  // ---------------------------------------------------------------

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  int send_gap = 0;

  // sender: holds a word until taken, then pauses or offers the next one
  always @(posedge clk) begin
    scan_item_t it;
    logic       nvalid;
    logic [47:0] ndata;
    logic       nuser;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else begin
      nvalid = s_tvalid;
      ndata  = s_tdata;
      nuser  = s_tuser;
      if (s_tvalid && s_tready) begin
        it.kind = s_tuser;
        it.x    = s_tdata[17:0];
        it.y    = s_tdata[35:18];
        it.rbin = s_tdata[44:36];
        track_item(it);
        words_in++;
        nvalid = 1'b0;
        send_gap = draw_gap();
      end
      if (!nvalid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          nvalid = 1'b1;
          ndata  = {3'b000, it.rbin, it.y, it.x};
          nuser  = it.kind;
        end
      end
      s_tvalid <= nvalid;
      s_tdata  <= ndata;
      s_tuser  <= nuser;
    end
  end

  // one long hold-off of the receiver, counted here, while the sender keeps going
  int hold_cnt = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (!hold_done && !long_hold && words_in >= 150) begin
      long_hold <= 1'b1;
      hold_cnt  <= HOLD_LEN;
    end else if (long_hold) begin
      if (hold_cnt == 0) begin
        long_hold <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  int recv_gap = 0;

  // receiver: checks each word against the oldest expectation
  always @(posedge clk) begin
    bin_word_t w;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        words_out++;
        if (m_tuser) empty_seen++;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: bin %0d range %0d empty %0b",
                     m_tdata[8:0], m_tdata[25:9], m_tuser);
        end else begin
          w = expected_words.pop_front();
          if (m_tdata[8:0] !== w.bin || m_tdata[25:9] !== w.range || m_tuser !== w.empty) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected bin %0d range %0d empty %0b, got %0d %0d %0b",
                       w.bin, w.range, w.empty, m_tdata[8:0], m_tdata[25:9], m_tuser);
          end
        end
        recv_gap = draw_gap();
      end
      if (long_hold) begin
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles where neither side moves a word
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_MAX) begin
      $display("timeout: no word moved for %0d cycles", stuck);
      $display("testbench: errors");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------

  function automatic scan_item_t point(longint x, longint y);
    scan_item_t it;
    it.kind = KIND_POINT;
    it.x    = x[17:0];
    it.y    = y[17:0];
    it.rbin = 9'($urandom());   // ignored for points, keeps the bits moving
    return it;
  endfunction

  function automatic scan_item_t read_of(int b);
    scan_item_t it;
    it.kind = KIND_READ;
    it.x    = 18'($urandom());
    it.y    = 18'($urandom());
    it.rbin = b[8:0];
    return it;
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_words.size() != 0);
    // points give no word, so let the last of them drain
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_range_ceil(logic [16:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    ceil_shadow = v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= 17'($urandom());
  endtask

  // random coordinate: mostly short ranges, some anywhere in the field
  function automatic longint coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return longint'($urandom_range(0, 4000)) - 2000;
    if (r < 8) return longint'($urandom_range(0, 200000)) - 100000;
    return longint'(18'sh0 + $signed(18'($urandom())));
  endfunction

  task automatic random_phase(int n);
    int hot [$];
    longint x, y;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        x = coord();
        y = coord();
        pending_items.push_back(point(x, y));
        hot.push_back(angle_bin(x, y));
      end else if (r < 90 && hot.size() > 0) begin
        pending_items.push_back(read_of(hot[$urandom_range(0, hot.size() - 1)]));
      end else if (r < 96) begin
        pending_items.push_back(read_of($urandom_range(0, NBINS - 1)));
      end else begin
        // out of range bin, no word
        pending_items.push_back(read_of($urandom_range(NBINS, 511)));
      end
    end
  endtask

  initial begin
    longint dx [12];
    longint dy [12];
    logic [16:0] settings [4];
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_data = '0;
    ceil_shadow = 17'd100000;
    for (int b = 0; b < NBINS; b++) shadow_min[b] = ptamr_pkg::RANGE_MASK;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: origin, axes, diagonals, field extremes, a far point
    dx = '{0, -5, 3, 0, 0, 100, -100, -77, 131071, -131072, 131071, 120000};
    dy = '{0, 0, 0, 7, -7, 100, 100, -77, 131071, -131072, -131072, 1};
    for (int i = 0; i < 12; i++) pending_items.push_back(point(dx[i], dy[i]));
    for (int i = 0; i < 12; i++) pending_items.push_back(read_of(angle_bin(dx[i], dy[i])));
    pending_items.push_back(read_of(NBINS));
    pending_items.push_back(read_of(511));
    pending_items.push_back(read_of(0));
    wait_idle();

    // register extremes and a couple of ordinary limits
    settings = '{17'd0, 17'd130071, 17'd5000, 17'($urandom_range(0, 130071))};
    for (int p = 0; p < 4; p++) begin
      write_range_ceil(settings[p]);
      random_phase(110);
      wait_idle();
    end

    $display("covered %0d items, %0d bin reads returned (%0d empty)",
             words_in, words_out, empty_seen);
    $display("range limits swept from 0 to 130071, with one long output stall");
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ptamr_pkg.sv
rtl/ptamr_geom.sv
rtl/point_to_angular_min_range_bins_unit.sv
verif/testbench.sv
